### hw/rtl/lade_pkg.sv
// ----------------------------------------------------------------------------
// lade_pkg - shared types and constants of the looping envelope
// Fixed-point formats, phase codes, register indexes and the envelope state
// record passed between the step logic and the top level.
// ----------------------------------------------------------------------------
package lade_pkg;

  // Level is unsigned Q1.24, rates are Q0.24
  localparam int LEVEL_W = 25;
  localparam int RATE_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [LEVEL_W:0] ONE_Q24 = (LEVEL_W+1)'(1) << RATE_W;
  localparam logic [LEVEL_W:0] TWO_Q24 = (LEVEL_W+1)'(2) << RATE_W;

  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(350);

  typedef logic [1:0] phase_t;

  localparam phase_t PH_OFF  = 2'd0;
  localparam phase_t PH_RISE = 2'd1;
  localparam phase_t PH_FALL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_RISE_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    phase_t             phase;
  } env_state_t;

endpackage

### hw/rtl/lade_step.sv
// ----------------------------------------------------------------------------
// lade_step - one sample step of the envelope
// Combinational next-state and result logic: trigger restart, rise with fold
// above 1.0, fall with loop fold or stop at zero.
// ----------------------------------------------------------------------------
module lade_step
  import lade_pkg::*;
(
  input  env_state_t          cur,
  input  logic                trigger,
  input  logic [RATE_W-1:0]   rise_rate,
  input  logic [RATE_W-1:0]   fall_rate,
  input  logic                loop_enable,
  output env_state_t          nxt,
  output logic [LEVEL_W-1:0]  res_level
);

  logic [RATE_W-1:0]   rise_eff;
  logic [RATE_W-1:0]   fall_eff;
  phase_t              ph;
  logic [LEVEL_W-1:0]  lv;
  logic [LEVEL_W:0]    sum;
  logic [LEVEL_W:0]    fold;
  logic [LEVEL_W:0]    diff;
  logic [LEVEL_W:0]    neg;

  // Treat a zero rate as the lowest legal rate
  assign rise_eff = (rise_rate == '0) ? RATE_W'(1) : rise_rate;
  assign fall_eff = (fall_rate == '0) ? RATE_W'(1) : fall_rate;

  // Restart from zero on a trigger
  assign ph = trigger ? PH_RISE : cur.phase;
  assign lv = trigger ? '0 : cur.level;

  // Rise and fall arithmetic, 26 bits wide to hold overshoot and sign
  assign sum  = {1'b0, lv} + {2'b00, rise_eff};
  assign fold = TWO_Q24 - sum;
  assign diff = {1'b0, lv} - {2'b00, fall_eff};
  assign neg  = '0 - diff;

  always_comb begin
    nxt.level = lv;
    nxt.phase = PH_OFF;
    res_level = '0;
    case (ph)
      PH_RISE: begin
        if (sum > ONE_Q24) begin
          nxt.level = fold[LEVEL_W-1:0];
          nxt.phase = PH_FALL;
        end else begin
          nxt.level = sum[LEVEL_W-1:0];
          nxt.phase = PH_RISE;
        end
        res_level = nxt.level;
      end
      PH_FALL: begin
        // Zero or below: fold back up in loop mode, otherwise stop
        if (diff[LEVEL_W] || (diff == '0)) begin
          if (loop_enable) begin
            nxt.level = neg[LEVEL_W-1:0];
            nxt.phase = PH_RISE;
          end else begin
            nxt.level = '0;
            nxt.phase = PH_OFF;
          end
        end else begin
          nxt.level = diff[LEVEL_W-1:0];
          nxt.phase = PH_FALL;
        end
        res_level = nxt.level;
      end
      default: begin
        // Off: hold the level, report zero
        nxt.level = lv;
        nxt.phase = PH_OFF;
        res_level = '0;
      end
    endcase
  end

endmodule

### hw/rtl/looping_ad_envelope.sv
// ----------------------------------------------------------------------------
// looping_ad_envelope - linear attack-decay envelope with loop mode
// One input transaction per audio sample carries a trigger flag; each one
// yields one result transaction with the level (unsigned Q1.24) and phase.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_trigger, one transaction per sample.
//   Result channel out_valid/out_ready/out_level/out_phase, one transaction
//   for every input transaction, in order.
//   Latency: the result is valid the cycle after the input is accepted.
//   Throughput: one sample per cycle unless out_ready stalls. The envelope state
//   updates at the accepting edge from the current state, so the single
//   add/subtract and compare of the step logic is the only path in the recurrence.
//   Stall: while a result waits and out_ready is low, in_ready drops and the
//   result and state hold; in_ready rises in the cycle out_ready takes it.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index
//   (0 rise_rate, 1 fall_rate, 2 loop_enable; other indexes are ignored).
//   Write only while idle. Enabling loop while off starts a rise from 0.
//   Reset (rst_n low, synchronous): rates 350, loop off, level 0, phase off,
//   no result pending.
// ----------------------------------------------------------------------------
module looping_ad_envelope
  import lade_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [RATE_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_trigger,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_W-1:0]    out_level,
  output phase_t                out_phase
);

  logic [RATE_W-1:0]   rise_rate_r;
  logic [RATE_W-1:0]   fall_rate_r;
  logic                loop_enable_r;
  env_state_t          state_r;
  env_state_t          state_nxt;
  logic [LEVEL_W-1:0]  res_level;
  logic                out_valid_r;
  logic [LEVEL_W-1:0]  out_level_r;
  phase_t              out_phase_r;
  logic                in_fire;

  // Accept whenever the result register is empty or being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  lade_step u_step (
    .cur         (state_r),
    .trigger     (in_trigger),
    .rise_rate   (rise_rate_r),
    .fall_rate   (fall_rate_r),
    .loop_enable (loop_enable_r),
    .nxt         (state_nxt),
    .res_level   (res_level)
  );

  // Configuration registers and envelope state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_rate_r   <= RATE_RESET;
      fall_rate_r   <= RATE_RESET;
      loop_enable_r <= 1'b0;
      state_r.level <= '0;
      state_r.phase <= PH_OFF;
    end else begin
      if (in_fire) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_RISE_RATE: rise_rate_r <= cfg_wdata;
          REG_FALL_RATE: fall_rate_r <= cfg_wdata;
          REG_LOOP_ENABLE: begin
            loop_enable_r <= cfg_wdata[0];
            // Start a rise when loop is switched on while off
            if (cfg_wdata[0] && (state_r.phase != PH_RISE)
                && (state_r.phase != PH_FALL)) begin
              state_r.level <= '0;
              state_r.phase <= PH_RISE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_level_r <= res_level;
      out_phase_r <= state_nxt.phase;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

`ifndef SYNTHESIS
  // Stored level never leaves [0, 1.0]
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, state_r.level} <= ONE_Q24)
    else $error("envelope level above 1.0");

  // An off result always reports zero
  a_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_phase_r == PH_OFF) |-> (out_level_r == '0))
    else $error("off result with nonzero level");

  // A falling result is strictly above zero
  a_fall_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_phase_r == PH_FALL) |-> (out_level_r != '0))
    else $error("falling result at zero");

  // A trigger always yields a rising result
  a_trigger_rise: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_trigger |=> (out_phase_r == PH_RISE))
    else $error("trigger did not restart the rise");
`endif

endmodule

### tb/looping_ad_envelope_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looping_ad_envelope_test - self-checking bench for the looping envelope
// Drives one trigger flag per sample through the valid/ready input channel,
// tracks the expected level and phase of every sample in a scoreboard, and
// checks each result transaction in order. A directed part walks the fold
// points, exact 1.0 and exact zero, zero and full-scale rates and loop
// switching; random segments then sweep rates, loop mode and trigger density
// under three idling patterns.
// ----------------------------------------------------------------------------
import lade_pkg::*;

class envelope_scoreboard;
  logic [RATE_W-1:0] rise_rate;
  logic [RATE_W-1:0] fall_rate;
  logic              loop_on;
  int                level;
  phase_t            phase;
  env_state_t        pending[$];
  int                errors;

  function new();
    rise_rate = RATE_RESET;
    fall_rate = RATE_RESET;
    loop_on   = 1'b0;
    level     = 0;
    phase     = PH_OFF;
    errors    = 0;
  endfunction

  // A rate of zero still moves the envelope by one step
  function int step_size(logic [RATE_W-1:0] rate);
    return (rate == '0) ? 1 : int'(rate);
  endfunction

  // Mirror a register write; enabling loop while off starts a rise from 0
  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [RATE_W-1:0] value);
    case (idx)
      REG_RISE_RATE: rise_rate = value;
      REG_FALL_RATE: fall_rate = value;
      REG_LOOP_ENABLE: begin
        loop_on = value[0];
        if (loop_on && phase != PH_RISE && phase != PH_FALL) begin
          level = 0;
          phase = PH_RISE;
        end
      end
      default: ;
    endcase
  endfunction

  // Advance the envelope by one accepted sample and queue its result
  function void note_sample(logic trig);
    env_state_t next_out;
    int         out_level;
    if (trig) begin
      phase = PH_RISE;
      level = 0;
    end
    if (phase == PH_RISE) begin
      level += step_size(rise_rate);
      if (level > int'(ONE_Q24)) begin
        phase = PH_FALL;
        level = int'(TWO_Q24) - level;
      end
      out_level = level;
    end else if (phase == PH_FALL) begin
      level -= step_size(fall_rate);
      if (level <= 0) begin
        if (loop_on) begin
          phase = PH_RISE;
          level = -level;
        end else begin
          level = 0;
          phase = PH_OFF;
        end
      end
      out_level = level;
    end else begin
      phase = PH_OFF;
      out_level = 0;
    end
    next_out.level = out_level[LEVEL_W-1:0];
    next_out.phase = phase;
    pending.push_back(next_out);
  endfunction

  // Compare one result transaction against the oldest expectation
  function void check_result(logic [LEVEL_W-1:0] got_level, phase_t got_phase);
    env_state_t want;
    if (pending.size() == 0) begin
      $error("unexpected result: level %0d, phase %0d", got_level, got_phase);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got_level !== want.level) begin
      $error("level: expected %0d, actual %0d", want.level, got_level);
      errors++;
    end
    if (got_phase !== want.phase) begin
      $error("phase: expected %0d, actual %0d", want.phase, got_phase);
      errors++;
    end
  endfunction
endclass

module looping_ad_envelope_test;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 300000;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATE_W-1:0]    cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_trigger;
  logic                 out_valid;
  logic                 out_ready;
  logic [LEVEL_W-1:0]   out_level;
  phase_t               out_phase;

  envelope_scoreboard sb;
  int send_gap_pct   = 23;
  int recv_stall_pct = 64;
  int cycle_count    = 0;

  looping_ad_envelope uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_trigger (in_trigger),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_level  (out_level),
    .out_phase  (out_phase)
  );

  always #10 clk = ~clk;

  // Accept results and randomize backpressure for the next cycle
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result(out_level, out_phase);
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offer one sample, idling first at random, and hold it until accepted
  task automatic send_sample(input logic trig);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_trigger <= trig;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(trig);
  endtask

  // Drop valid and wait for every outstanding result to come back
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly fast rates so segments reach the folds; powers of two hit 1.0 and 0 exactly
  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return RATE_W'($urandom_range(1, 4095));
      3, 4:    return RATE_W'(1) << $urandom_range(18, 23);
      default: return RATE_W'($urandom_range(24'h100000, 24'hFFFFFF));
    endcase
  endfunction

  // Random segments: fresh settings, then a run of samples with a set trigger density
  task automatic run_segments(input int gap_pct, input int stall_pct, input int n_items);
    int sent;
    int seg_len;
    int trig_pct;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      drain();
      if ($urandom_range(1)) write_reg(REG_LOOP_ENABLE, RATE_W'($urandom_range(1)));
      write_reg(REG_RISE_RATE, pick_rate());
      write_reg(REG_FALL_RATE, pick_rate());
      if ($urandom_range(3) == 0) write_reg(REG_SPARE, RATE_W'($urandom));
      if ($urandom_range(1)) write_reg(REG_LOOP_ENABLE, RATE_W'($urandom_range(1)));
      case ($urandom_range(3))
        0:       trig_pct = 0;
        1:       trig_pct = 3;
        2:       trig_pct = 10;
        default: trig_pct = 50;
      endcase
      seg_len = $urandom_range(15, 60);
      repeat (seg_len) send_sample($urandom_range(99) < trig_pct);
      sent += seg_len;
    end
  endtask

  initial begin
    sb = new();
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_RISE_RATE;
    cfg_wdata  <= '0;
    in_valid   <= 1'b0;
    in_trigger <= 1'b0;
    out_ready  <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset rates: off samples read 0, then a trigger starts the rise
    send_sample(1'b0);
    send_sample(1'b0);
    send_sample(1'b1);
    send_sample(1'b0);

    // Half-scale rise reaches exactly 1.0, folds, and falls to exactly zero
    drain();
    write_reg(REG_RISE_RATE, 24'h800000);
    write_reg(REG_FALL_RATE, 24'h400000);
    send_sample(1'b1);
    repeat (5) send_sample(1'b0);

    // Enable loop while off; exact zero on the fall turns back into a rise
    drain();
    write_reg(REG_LOOP_ENABLE, 24'd1);
    repeat (5) send_sample(1'b0);

    // Loop rewritten while rising, zero rise rate, full fall rate, unused index
    drain();
    write_reg(REG_LOOP_ENABLE, 24'd1);
    write_reg(REG_RISE_RATE, '0);
    write_reg(REG_FALL_RATE, '1);
    write_reg(REG_SPARE, '1);
    send_sample(1'b1);
    send_sample(1'b0);

    // Full-scale rise folds to just under 1.0, one full step lands on zero
    drain();
    write_reg(REG_RISE_RATE, '1);
    repeat (3) send_sample(1'b0);

    // Zero fall rate, loop off mid-rise: the fall ends exactly at zero and stops
    drain();
    write_reg(REG_FALL_RATE, '0);
    write_reg(REG_LOOP_ENABLE, 24'd0);
    repeat (4) send_sample(1'b0);

    run_segments(23, 64, 470);
    run_segments(64, 23, 470);
    run_segments(0, 0, 460);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
